// ----- rtl/tsi_pkg.sv -----
// Package for the turtle symbol interpreter: symbol codes, status codes,
// register indexes, reset values and the result item type.
// No dependencies.
package tsi_pkg;

  // default sizes
  localparam int STACK_DEPTH_DEF = 64;
  localparam int COORD_WIDTH_DEF = 16;

  // symbol bytes
  localparam logic [7:0] SYM_MOVE  = 8'h46;
  localparam logic [7:0] SYM_LEFT  = 8'h2B;
  localparam logic [7:0] SYM_RIGHT = 8'h2D;
  localparam logic [7:0] SYM_PUSH  = 8'h5B;
  localparam logic [7:0] SYM_POP   = 8'h5D;

  // result status codes
  localparam logic [1:0] ST_LINE      = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_COS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_X0    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_Y0    = 3'd4;
  localparam int CFG_DATA_W = 16;

  // register reset values
  localparam logic signed [15:0] COS_RST  = 16'sd14189;
  localparam logic signed [15:0] SIN_RST  = 16'sd8192;
  localparam logic [14:0]        STEP_RST = 15'd8;
  localparam logic [11:0]        X0_RST   = 12'd320;
  localparam logic [11:0]        Y0_RST   = 12'd480;

  // one result item
  typedef struct packed {
    logic signed [15:0] line_x0;
    logic signed [15:0] line_y0;
    logic signed [15:0] line_x1;
    logic signed [15:0] line_y1;
    logic [1:0]         status;
  } res_t;

endpackage

// ----- rtl/turtle_symbol_interpreter.sv -----
// Turtle symbol interpreter top level: pen, heading and stack control.
// Depends on tsi_pkg and tsi_ram.
//
// Takes one symbol item per clock while in_stall is low; a move returns a
// line item, a failed push or pop a stack error item. The heading rotation
// (four 32x16 multiplies, a sum, rounding and saturation) is combinational,
// so turns, moves, pushes and pops run back to back at one item per cycle
// when not stalled. The saved pen and heading stack lives in one RAM; its
// top two entries are held in registers, and a pop refills the second one
// from the RAM, whose data is forwarded in the following cycle. Results
// pass through an output register and a skid register, so in_stall rises
// only when both are full. No clearing pass is needed after reset.
module turtle_symbol_interpreter import tsi_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // symbol items
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_symbol,
  input  logic                   in_first_of_string,
  // result items
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [15:0]     out_line_x0,
  output logic signed [15:0]     out_line_y0,
  output logic signed [15:0]     out_line_x1,
  output logic signed [15:0]     out_line_y1,
  output logic [1:0]             out_status
);

  localparam int CW   = COORD_WIDTH;
  localparam int AW   = $clog2(STACK_DEPTH);
  localparam int CNTW = $clog2(STACK_DEPTH + 1);
  localparam int EW   = 2 * CW + 64;
  localparam logic signed [31:0] CMAX = 32'sd1 <<< (CW - 1);
  localparam logic signed [31:0] C_HI = CMAX - 32'sd1;
  localparam logic signed [31:0] C_LO = -CMAX;
  localparam logic [CNTW-1:0]    CNT_FULL = CNTW'(STACK_DEPTH);

  // saturate a 32 bit coordinate to the pen range
  function automatic logic signed [CW-1:0] sat_coord(input logic signed [31:0] v);
    logic signed [31:0] c;
    c = (v > C_HI) ? C_HI : ((v < C_LO) ? C_LO : v);
    return c[CW-1:0];
  endfunction

  // saturate a pen coordinate to the 16 bit output range
  function automatic logic signed [15:0] sat_out(input logic signed [CW-1:0] v);
    logic signed [31:0] w;
    logic signed [31:0] c;
    w = 32'(v);
    c = (w > 32'sd32767) ? 32'sd32767 : ((w < -32'sd32768) ? -32'sd32768 : w);
    return c[15:0];
  endfunction

  // round a Q2.14 scaled sum back to Q16.16 with saturation
  function automatic logic signed [31:0] round_q14(input logic signed [48:0] v);
    logic signed [48:0] r;
    logic signed [34:0] s;
    r = v + 49'sd8192;
    s = 35'(r >>> 14);
    if (s > 35'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (s < -35'sd2147483648) begin
      return 32'sh80000000;
    end
    return s[31:0];
  endfunction

  // truncate Q16.16 toward zero
  function automatic logic signed [31:0] trunc_q16(input logic signed [31:0] h);
    logic signed [31:0] f;
    f = 32'(signed'(h[31:16]));
    if (h[31] && (h[15:0] != 16'h0)) begin
      f = f + 32'sd1;
    end
    return f;
  endfunction

  // configuration registers
  logic signed [15:0] cos_r, sin_r;
  logic [14:0]        step_r;
  logic [11:0]        x0_r, y0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_r  <= COS_RST;
      sin_r  <= SIN_RST;
      step_r <= STEP_RST;
      x0_r   <= X0_RST;
      y0_r   <= Y0_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_COS:  cos_r  <= cfg_data;
        REG_SIN:  sin_r  <= cfg_data;
        REG_STEP: step_r <= cfg_data[14:0];
        REG_X0:   x0_r   <= cfg_data[11:0];
        REG_Y0:   y0_r   <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // turtle state, top of stack and the entry below it
  logic signed [CW-1:0] pen_x_r, pen_y_r;
  logic signed [31:0]   hx_r, hy_r;
  logic [CNTW-1:0]      cnt_r;
  logic [EW-1:0]        tos_r, under_r;
  logic                 use_rd_r;
  logic [EW-1:0]        ram_rd_data;

  // next values of the turtle and stack state
  logic signed [CW-1:0] pen_x_nxt, pen_y_nxt;
  logic signed [31:0]   hx_nxt, hy_nxt;
  logic [CNTW-1:0]      cnt_nxt;
  logic [EW-1:0]        tos_nxt, under_nxt;
  logic                 use_rd_nxt;

  // output register and skid register
  res_t out_r, skid_r;
  logic out_valid_r, skid_valid_r;

  logic in_acc, out_take;
  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !skid_valid_r;
  assign out_take = out_valid_r && !out_stall;

  // state seen by this item, after a string restart if flagged
  logic signed [CW-1:0] pen_x_b, pen_y_b;
  logic signed [31:0]   hx_b, hy_b;
  logic [CNTW-1:0]      cnt_b;

  always_comb begin
    if (in_first_of_string) begin
      pen_x_b = sat_coord(32'(x0_r));
      pen_y_b = sat_coord(32'(y0_r));
      hx_b    = 32'sd0;
      hy_b    = {1'b0, step_r, 16'h0};
      cnt_b   = '0;
    end else begin
      pen_x_b = pen_x_r;
      pen_y_b = pen_y_r;
      hx_b    = hx_r;
      hy_b    = hy_r;
      cnt_b   = cnt_r;
    end
  end

  // heading rotation
  logic signed [47:0] pxc, pys, pxs, pyc;
  logic signed [31:0] rot_x, rot_y;

  always_comb begin
    pxc = hx_b * cos_r;
    pys = hy_b * sin_r;
    pxs = hx_b * sin_r;
    pyc = hy_b * cos_r;
    if (in_symbol == SYM_LEFT) begin
      rot_x = round_q14(49'(pxc) - 49'(pys));
      rot_y = round_q14(49'(pxs) + 49'(pyc));
    end else begin
      rot_x = round_q14(49'(pxc) + 49'(pys));
      rot_y = round_q14(49'(pyc) - 49'(pxs));
    end
  end

  // pen move
  logic signed [CW-1:0] move_x, move_y;
  assign move_x = sat_coord(32'(pen_x_b) + trunc_q16(hx_b));
  assign move_y = sat_coord(32'(pen_y_b) - trunc_q16(hy_b));

  // symbol decode
  logic is_move, is_turn, is_push, is_pop, push_ok, pop_ok;
  assign is_move = (in_symbol == SYM_MOVE);
  assign is_turn = (in_symbol == SYM_LEFT) || (in_symbol == SYM_RIGHT);
  assign is_push = (in_symbol == SYM_PUSH);
  assign is_pop  = (in_symbol == SYM_POP);
  assign push_ok = is_push && (cnt_b < CNT_FULL);
  assign pop_ok  = is_pop && (cnt_b != '0);

  // entry below the top, refreshed from the RAM after a pop
  logic [EW-1:0] under_eff;
  assign under_eff = use_rd_r ? ram_rd_data : under_r;

  // stack RAM access
  logic            ram_wr_en, ram_rd_en;
  logic [AW-1:0]   ram_wr_addr, ram_rd_addr;
  logic [CNTW-1:0] cnt_m1, cnt_m3;
  assign cnt_m1      = cnt_b - CNTW'(1);
  assign cnt_m3      = cnt_b - CNTW'(3);
  assign ram_wr_en   = in_acc && push_ok && (cnt_b != '0);
  assign ram_wr_addr = cnt_m1[AW-1:0];
  assign ram_rd_en   = in_acc && pop_ok;
  assign ram_rd_addr = cnt_m3[AW-1:0];

  tsi_ram #(
    .WIDTH (EW),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (tos_r),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // result of this item
  logic res_v;
  res_t res;

  always_comb begin
    res_v = in_acc && (is_move || (is_push && !push_ok) || (is_pop && !pop_ok));
    res   = '0;
    if (is_move) begin
      res.line_x0 = sat_out(pen_x_b);
      res.line_y0 = sat_out(pen_y_b);
      res.line_x1 = sat_out(move_x);
      res.line_y1 = sat_out(move_y);
      res.status  = ST_LINE;
    end else if (is_push) begin
      res.status = ST_OVERFLOW;
    end else begin
      res.status = ST_UNDERFLOW;
    end
  end

  // turtle and stack next state
  always_comb begin
    pen_x_nxt  = pen_x_r;
    pen_y_nxt  = pen_y_r;
    hx_nxt     = hx_r;
    hy_nxt     = hy_r;
    cnt_nxt    = cnt_r;
    tos_nxt    = tos_r;
    under_nxt  = under_eff;
    use_rd_nxt = 1'b0;
    if (in_acc) begin
      pen_x_nxt = pen_x_b;
      pen_y_nxt = pen_y_b;
      hx_nxt    = hx_b;
      hy_nxt    = hy_b;
      cnt_nxt   = cnt_b;
      if (is_move) begin
        pen_x_nxt = move_x;
        pen_y_nxt = move_y;
      end else if (is_turn) begin
        hx_nxt = rot_x;
        hy_nxt = rot_y;
      end else if (push_ok) begin
        tos_nxt   = {pen_x_b, pen_y_b, hx_b, hy_b};
        under_nxt = tos_r;
        cnt_nxt   = cnt_b + CNTW'(1);
      end else if (pop_ok) begin
        {pen_x_nxt, pen_y_nxt, hx_nxt, hy_nxt} = tos_r;
        tos_nxt    = under_eff;
        use_rd_nxt = 1'b1;
        cnt_nxt    = cnt_m1;
      end
    end
  end

  // turtle and stack state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r  <= sat_coord(32'(X0_RST));
      pen_y_r  <= sat_coord(32'(Y0_RST));
      hx_r     <= 32'sd0;
      hy_r     <= {1'b0, STEP_RST, 16'h0};
      cnt_r    <= '0;
      use_rd_r <= 1'b0;
    end else begin
      pen_x_r  <= pen_x_nxt;
      pen_y_r  <= pen_y_nxt;
      hx_r     <= hx_nxt;
      hy_r     <= hy_nxt;
      cnt_r    <= cnt_nxt;
      tos_r    <= tos_nxt;
      under_r  <= under_nxt;
      use_rd_r <= use_rd_nxt;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (res_v) begin
      if (!out_valid_r || out_take) begin
        out_r       <= res;
        out_valid_r <= 1'b1;
      end else begin
        skid_r       <= res;
        skid_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_line_x0 = out_r.line_x0;
  assign out_line_y0 = out_r.line_y0;
  assign out_line_x1 = out_r.line_x1;
  assign out_line_y1 = out_r.line_y1;
  assign out_status  = out_r.status;

  // stack fill never passes the depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("stack count beyond depth");

  // skid entry only exists behind a full output register
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid valid with empty output register");

  // a good pop removes exactly one entry
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && pop_ok) |=> (cnt_r == $past(cnt_m1)))
    else $error("pop did not drop the stack count by one");

endmodule

// ----- rtl/tsi_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tsi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
